// ===== design/wpas_pkg.sv =====
// Shared constants, widths and controller/datapath interface structs for the
// waypoint advance selector. No dependencies.

package wpas_pkg;

    localparam int PATH_DEPTH_DEF = 1024;

    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 23;
    localparam int SKIP_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int LEFT_W     = 11;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [RADIUS_W-1:0] REACH_RADIUS_RST = 23'd9175;
    localparam logic [RADIUS_W-1:0] SKIP_RADIUS_RST  = 23'd7864;
    localparam logic [SKIP_W-1:0]   BULK_SKIP_RST    = 8'd7;
    localparam logic [COORD_W-1:0]  GOAL_X_RST       = 24'd0;
    localparam logic [COORD_W-1:0]  GOAL_Y_RST       = 24'd9175;

    // Input word kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_GOAL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PATH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic goal_from_item;
        logic goal_from_mem;
        logic clear_path;
        logic write_point;
        logic mem_read;
        logic sub_from_mem;
        logic bulk_drop;
        logic keep_one;
        logic drop_one;
        logic load_out;
        logic emitted;
        logic dropped;
    } wpas_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              last;
        logic              cnt_zero;
        logic              cnt_gt1;
        logic              cnt_long;
        logic              full;
        logic              near;
        logic              close;
        logic              out_free;
    } wpas_sts_t;

endpackage

// ===== design/waypoint_advance_selector.sv =====
// Waypoint advance selector, top level: configuration registers with their
// register port, controller and datapath. Depends on wpas_pkg, wpas_ctrl, wpas_dpath.
//
// Input words arrive on s_tvalid/s_tready: tuser carries the kind (goal point,
// path point, position tick), tdata the point or position, tlast closes a path
// message. Every input word yields exactly one result word on m_tvalid/m_tready.
// A tick that advances walks its skip search one point at a time through the path
// store's single read port and the three-stage distance-squared pipeline.
// One word is worked on at a time; s_tready is high only between words, so the
// next word is accepted at the earliest in the cycle after the result is loaded.
// The result register lets that word be accepted while a result waits; if the
// receiver keeps m_tready low, the finished word waits until the slot frees.
// Reset clears path store count, pointers and message phase, sets the target to
// (0, 0.14 m) and the radii and bulk skip to their defaults. The store memory
// itself is not cleared; there is no clearing pass.

module waypoint_advance_selector
    import wpas_pkg::*;
#(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y
    input  logic                  s_tlast,
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // target_x, target_y, points_left
    output logic [OUT_USER_W-1:0] m_tuser    // emitted, point_dropped
);

    localparam logic [1:0] REG_REACH = 2'd0;
    localparam logic [1:0] REG_SKIP  = 2'd1;
    localparam logic [1:0] REG_BULK  = 2'd2;

    logic [RADIUS_W-1:0] reach_radius_reg;
    logic [RADIUS_W-1:0] skip_radius_reg;
    logic [SKIP_W-1:0]   bulk_skip_reg;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    wpas_cmd_t           cmd;
    wpas_sts_t           sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_radius_reg <= REACH_RADIUS_RST;
            skip_radius_reg  <= SKIP_RADIUS_RST;
            bulk_skip_reg    <= BULK_SKIP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REACH: reach_radius_reg <= pwdata[RADIUS_W-1:0];
                REG_SKIP:  skip_radius_reg  <= pwdata[RADIUS_W-1:0];
                REG_BULK:  bulk_skip_reg    <= pwdata[SKIP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_REACH: prdata = PDATA_W'(reach_radius_reg);
            REG_SKIP:  prdata = PDATA_W'(skip_radius_reg);
            REG_BULK:  prdata = PDATA_W'(bulk_skip_reg);
            default:   prdata = '0;
        endcase
    end

    wpas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpas_dpath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tuser      (s_tuser),
        .reach_radius (reach_radius_reg),
        .skip_radius  (skip_radius_reg),
        .bulk_skip    (bulk_skip_reg),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ===== design/wpas_ctrl.sv =====
// Sequencing controller of the waypoint advance selector: message phase,
// accept toggle and the per-item state machine. Depends on wpas_pkg.

module wpas_ctrl
    import wpas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  wpas_sts_t sts,
    output wpas_cmd_t cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_PATH_RD  = 4'd2;
    localparam logic [3:0] ST_PATH_LD  = 4'd3;
    localparam logic [3:0] ST_TICK_SUB = 4'd4;
    localparam logic [3:0] ST_TICK_SQ  = 4'd5;
    localparam logic [3:0] ST_TICK_CMP = 4'd6;
    localparam logic [3:0] ST_BULK     = 4'd7;
    localparam logic [3:0] ST_KEEP_ONE = 4'd8;
    localparam logic [3:0] ST_SKIP_RD  = 4'd9;
    localparam logic [3:0] ST_SKIP_SUB = 4'd10;
    localparam logic [3:0] ST_SKIP_SQ  = 4'd11;
    localparam logic [3:0] ST_SKIP_CMP = 4'd12;
    localparam logic [3:0] ST_FRONT_RD = 4'd13;
    localparam logic [3:0] ST_FRONT_LD = 4'd14;
    localparam logic [3:0] ST_RESULT   = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       toggle_reg;
    logic       toggle_next;
    logic       emit_reg;
    logic       emit_next;
    logic       drop_reg;
    logic       drop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_IDLE;
            toggle_reg <= 1'b0;
            emit_reg   <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            toggle_reg <= toggle_next;
            emit_reg   <= emit_next;
            drop_reg   <= drop_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        emit_next   = emit_reg;
        drop_next   = drop_reg;
        cmd         = '0;
        cmd.emitted = emit_reg;
        cmd.dropped = drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    emit_next   = 1'b0;
                    drop_next   = 1'b0;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                case (sts.func)
                    FUNC_GOAL:
                    begin
                        cmd.goal_from_item = 1'b1;
                        emit_next          = 1'b1;
                        state_next         = ST_RESULT;
                    end
                    FUNC_PATH:
                    begin
                        state_next = ST_RESULT;
                        case (phase_reg)
                            PH_LOAD:
                            begin
                                if (!sts.full)
                                    cmd.write_point = 1'b1;
                                else
                                    drop_next = 1'b1;
                                // End of message: fetch the front as new target
                                if (sts.last)
                                begin
                                    toggle_next = 1'b0;
                                    phase_next  = PH_IDLE;
                                    state_next  = ST_PATH_RD;
                                end
                            end
                            PH_SKIP:
                            begin
                                drop_next = 1'b1;
                                if (sts.last)
                                    phase_next = PH_IDLE;
                            end
                            default:
                            begin
                                if (!toggle_reg)
                                begin
                                    toggle_next = 1'b1;
                                    drop_next   = 1'b1;
                                    phase_next  = sts.last ? PH_IDLE : PH_SKIP;
                                end
                                else
                                begin
                                    // Clear the store; the first point is discarded
                                    cmd.clear_path = 1'b1;
                                    if (sts.last)
                                    begin
                                        toggle_next = 1'b0;
                                        phase_next  = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LOAD;
                                    end
                                end
                            end
                        endcase
                    end
                    FUNC_TICK:
                    begin
                        state_next = ST_TICK_SUB;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_PATH_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_PATH_LD;
            end

            ST_PATH_LD:
            begin
                cmd.goal_from_mem = 1'b1;
                state_next        = ST_RESULT;
            end

            ST_TICK_SUB:
            begin
                cmd.sub_from_mem = 1'b0;
                state_next       = ST_TICK_SQ;
            end

            ST_TICK_SQ:
            begin
                state_next = ST_TICK_CMP;
            end

            ST_TICK_CMP:
            begin
                if (sts.near && !sts.cnt_zero)
                    state_next = sts.cnt_long ? ST_BULK : ST_KEEP_ONE;
                else
                    state_next = ST_RESULT;
            end

            ST_BULK:
            begin
                cmd.bulk_drop = 1'b1;
                state_next    = ST_SKIP_RD;
            end

            ST_KEEP_ONE:
            begin
                cmd.keep_one = 1'b1;
                state_next   = ST_FRONT_RD;
            end

            ST_SKIP_RD:
            begin
                // The word read here is the front whichever way the walk ends
                cmd.mem_read = 1'b1;
                state_next   = sts.cnt_gt1 ? ST_SKIP_SUB : ST_FRONT_LD;
            end

            ST_SKIP_SUB:
            begin
                cmd.sub_from_mem = 1'b1;
                state_next       = ST_SKIP_SQ;
            end

            ST_SKIP_SQ:
            begin
                state_next = ST_SKIP_CMP;
            end

            ST_SKIP_CMP:
            begin
                if (sts.close)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = ST_SKIP_RD;
                end
                else
                begin
                    state_next = ST_FRONT_LD;
                end
            end

            ST_FRONT_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_FRONT_LD;
            end

            ST_FRONT_LD:
            begin
                cmd.goal_from_mem = 1'b1;
                cmd.drop_one      = 1'b1;
                emit_next         = 1'b1;
                state_next        = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_DECODE)
        else $error("accepted word not followed by decode");

    a_load_needs_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LOAD |-> toggle_reg)
        else $error("path loading without accept toggle set");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free && !(emit_reg && drop_reg))
        else $error("result loaded into busy slot or with conflicting flags");
`endif

endmodule

// ===== design/wpas_dpath.sv =====
// Datapath of the waypoint advance selector: path store memory, head/tail/count,
// target, distance-squared pipeline and output register. Depends on wpas_pkg.

module wpas_dpath
    import wpas_pkg::*;
#(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic [RADIUS_W-1:0]   reach_radius,
    input  logic [RADIUS_W-1:0]   skip_radius,
    input  logic [SKIP_W-1:0]     bulk_skip,
    input  wpas_cmd_t             cmd,
    output wpas_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int IW     = $clog2(PATH_DEPTH);
    localparam int CW     = $clog2(PATH_DEPTH + 1);
    localparam int SW     = (IW + 1 > SKIP_W + 1) ? IW + 1 : SKIP_W + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RSQ_W  = 2 * RADIUS_W;
    localparam int PAD_W  = OUT_DATA_W - LEFT_W - 2 * COORD_W;
    localparam int WORD_W = 2 * COORD_W;

    localparam logic [SW-1:0] DEPTH_S  = SW'(PATH_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(PATH_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(PATH_DEPTH - 1);

    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] v);
        return (v >= DEPTH_S) ? IW'(v - DEPTH_S) : IW'(v);
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
        return (v == LAST_IDX) ? '0 : v + IW'(1);
    endfunction

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic [WORD_W-1:0]     mem [PATH_DEPTH];
    logic [WORD_W-1:0]     rdata_reg;

    logic [FUNC_W-1:0]     item_func_reg;
    logic                  item_last_reg;
    logic [COORD_W-1:0]    item_x_reg;
    logic [COORD_W-1:0]    item_y_reg;

    logic [COORD_W-1:0]    goal_x_reg;
    logic [COORD_W-1:0]    goal_x_next;
    logic [COORD_W-1:0]    goal_y_reg;
    logic [COORD_W-1:0]    goal_y_next;

    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         head_next;
    logic [IW-1:0]         tail_reg;
    logic [IW-1:0]         tail_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic [DIFF_W-1:0]     ux_reg;
    logic [DIFF_W-1:0]     uy_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [RSQ_W-1:0]      reach_sq_reg;
    logic [RSQ_W-1:0]      skip_sq_reg;
    logic [SUM_W-1:0]      dist_sq;
    logic [COORD_W-1:0]    ref_x;
    logic [COORD_W-1:0]    ref_y;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    // Path store: one write port at the tail, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.write_point)
            mem[tail_reg] <= {item_y_reg, item_x_reg};
        if (cmd.mem_read)
            rdata_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_func_reg <= s_tuser;
            item_last_reg <= s_tlast;
            item_x_reg    <= s_tdata[COORD_W-1:0];
            item_y_reg    <= s_tdata[WORD_W-1:COORD_W];
        end
    end

    always_comb
    begin
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        if (cmd.goal_from_item)
        begin
            goal_x_next = item_x_reg;
            goal_y_next = item_y_reg;
        end
        else if (cmd.goal_from_mem)
        begin
            goal_x_next = rdata_reg[COORD_W-1:0];
            goal_y_next = rdata_reg[WORD_W-1:COORD_W];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear_path)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.write_point)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.bulk_drop)
        begin
            // Only issued when count exceeds bulk_skip + 1, so no underflow
            head_next  = wrap_idx(SW'(head_reg) + SW'(bulk_skip));
            count_next = CW'(SW'(count_reg) - SW'(bulk_skip));
        end
        else if (cmd.keep_one)
        begin
            head_next  = wrap_idx(SW'(head_reg) + SW'(count_reg) - SW'(1));
            count_next = CW'(1);
        end
        else if (cmd.drop_one && count_reg != '0)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= GOAL_X_RST;
            goal_y_reg <= GOAL_Y_RST;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // Distance pipeline: difference magnitude, then squares, then compare
    assign ref_x = cmd.sub_from_mem ? rdata_reg[COORD_W-1:0] : goal_x_reg;
    assign ref_y = cmd.sub_from_mem ? rdata_reg[WORD_W-1:COORD_W] : goal_y_reg;

    always_ff @(posedge clk)
    begin
        ux_reg       <= abs_diff(ref_x, item_x_reg);
        uy_reg       <= abs_diff(ref_y, item_y_reg);
        sqx_reg      <= ux_reg * ux_reg;
        sqy_reg      <= uy_reg * uy_reg;
        reach_sq_reg <= reach_radius * reach_radius;
        skip_sq_reg  <= skip_radius * skip_radius;
    end

    assign dist_sq = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);

    always_comb
    begin
        sts.func     = item_func_reg;
        sts.last     = item_last_reg;
        sts.cnt_zero = (count_reg == '0);
        sts.cnt_gt1  = (count_reg > CW'(1));
        sts.cnt_long = (SW'(count_reg) > SW'(bulk_skip) + SW'(1));
        sts.full     = (count_reg == DEPTH_C);
        sts.near     = (dist_sq < SUM_W'(reach_sq_reg));
        sts.close    = (dist_sq < SUM_W'(skip_sq_reg));
        sts.out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, LEFT_W'(count_reg), goal_y_reg, goal_x_reg};
            out_user_reg <= {cmd.dropped, cmd.emitted};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("point count beyond store depth");

    a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == wrap_idx(SW'(head_reg) + SW'(count_reg)))
        else $error("tail pointer out of step with head and count");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for waypoint_advance_selector: a target predictor in a class
// checks every result word. Depends on wpas_pkg and the RTL of the block.

package wpas_tb_pkg;
    import wpas_pkg::*;

    localparam logic [PADDR_W-1:0] REG_REACH = 4'h0;
    localparam logic [PADDR_W-1:0] REG_SKIP  = 4'h4;
    localparam logic [PADDR_W-1:0] REG_BULK  = 4'h8;

    typedef enum logic [1:0] {MSG_WAIT, MSG_TAKE, MSG_IGNORE} msg_phase_t;

    typedef struct {
        bit                 emitted;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [LEFT_W-1:0]  left;
        bit                 dropped;
    } target_word_t;

    class target_predictor;
        logic [COORD_W-1:0]  path_x [PATH_DEPTH_DEF];
        logic [COORD_W-1:0]  path_y [PATH_DEPTH_DEF];
        int unsigned         head;
        int unsigned         count;
        logic [COORD_W-1:0]  tgt_x;
        logic [COORD_W-1:0]  tgt_y;
        bit                  toggle;
        msg_phase_t          phase;
        logic [RADIUS_W-1:0] reach_r;
        logic [RADIUS_W-1:0] skip_r;
        logic [SKIP_W-1:0]   bulk;
        target_word_t        expected_targets [$];
        int                  errors;

        function new();
            head    = 0;
            count   = 0;
            tgt_x   = GOAL_X_RST;
            tgt_y   = GOAL_Y_RST;
            toggle  = 1'b0;
            phase   = MSG_WAIT;
            reach_r = REACH_RADIUS_RST;
            skip_r  = SKIP_RADIUS_RST;
            bulk    = BULK_SKIP_RST;
            errors  = 0;
        endfunction

        function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
            case (addr)
                REG_REACH: reach_r = value[RADIUS_W-1:0];
                REG_SKIP:  skip_r  = value[RADIUS_W-1:0];
                REG_BULK:  bulk    = value[SKIP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PDATA_W-1:0] register_value(logic [PADDR_W-1:0] addr);
            logic [PDATA_W-1:0] v;
            v = '0;
            case (addr)
                REG_REACH: v = PDATA_W'(reach_r);
                REG_SKIP:  v = PDATA_W'(skip_r);
                REG_BULK:  v = PDATA_W'(bulk);
                default: ;
            endcase
            return v;
        endfunction

        function longint dist2(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                               logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        function void drop_front();
            if (count == 0)
                return;
            head  = (head + 1) % PATH_DEPTH_DEF;
            count = count - 1;
        endfunction

        // Advance the predicted state by one accepted word and queue its result
        function void note_word(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] cx,
                                logic [COORD_W-1:0] cy, bit last);
            target_word_t w;
            longint       reach_sq;
            longint       skip_sq;
            int unsigned  slot;
            w.emitted = 1'b0;
            w.dropped = 1'b0;
            reach_sq  = longint'(reach_r) * longint'(reach_r);
            skip_sq   = longint'(skip_r) * longint'(skip_r);
            case (f)
                FUNC_GOAL:
                begin
                    tgt_x     = cx;
                    tgt_y     = cy;
                    w.emitted = 1'b1;
                end
                FUNC_PATH:
                begin
                    case (phase)
                        MSG_TAKE:
                        begin
                            if (count < PATH_DEPTH_DEF)
                            begin
                                slot         = (head + count) % PATH_DEPTH_DEF;
                                path_x[slot] = cx;
                                path_y[slot] = cy;
                                count        = count + 1;
                            end
                            else
                                w.dropped = 1'b1;
                            if (last)
                            begin
                                if (count > 0)
                                begin
                                    tgt_x = path_x[head];
                                    tgt_y = path_y[head];
                                end
                                toggle = 1'b0;
                                phase  = MSG_WAIT;
                            end
                        end
                        MSG_IGNORE:
                        begin
                            w.dropped = 1'b1;
                            if (last)
                                phase = MSG_WAIT;
                        end
                        default:
                        begin
                            if (!toggle)
                            begin
                                toggle    = 1'b1;
                                w.dropped = 1'b1;
                                phase     = last ? MSG_WAIT : MSG_IGNORE;
                            end
                            else
                            begin
                                // the opening point only clears the store
                                head  = 0;
                                count = 0;
                                if (last)
                                begin
                                    toggle = 1'b0;
                                    phase  = MSG_WAIT;
                                end
                                else
                                    phase = MSG_TAKE;
                            end
                        end
                    endcase
                end
                FUNC_TICK:
                begin
                    if (count > 0 && dist2(tgt_x, tgt_y, cx, cy) < reach_sq)
                    begin
                        if (count > int'(bulk) + 1)
                        begin
                            for (int k = 0; k < int'(bulk); k++)
                                drop_front();
                            while (count > 1 && dist2(path_x[head], path_y[head], cx, cy) < skip_sq)
                                drop_front();
                        end
                        else
                        begin
                            while (count > 1)
                                drop_front();
                        end
                        tgt_x     = path_x[head];
                        tgt_y     = path_y[head];
                        w.emitted = 1'b1;
                        drop_front();
                    end
                end
                default: ;
            endcase
            w.tx   = tgt_x;
            w.ty   = tgt_y;
            w.left = count[LEFT_W-1:0];
            expected_targets.insert(expected_targets.size(), w);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            target_word_t w;
            if (expected_targets.size() == 0)
            begin
                report("unexpected result word", data, 0);
                return;
            end
            w = expected_targets.pop_front();
            if (user[0] !== w.emitted)
                report("emitted", user[0], w.emitted);
            if (user[1] !== w.dropped)
                report("point_dropped", user[1], w.dropped);
            if (data[COORD_W-1:0] !== w.tx)
                report("target_x", data[COORD_W-1:0], w.tx);
            if (data[2*COORD_W-1:COORD_W] !== w.ty)
                report("target_y", data[2*COORD_W-1:COORD_W], w.ty);
            if (data[2*COORD_W+LEFT_W-1:2*COORD_W] !== w.left)
                report("points_left", data[2*COORD_W+LEFT_W-1:2*COORD_W], w.left);
        endtask
    endclass
endpackage

module tb;
    import wpas_pkg::*;
    import wpas_tb_pkg::*;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    target_predictor tracker = new();
    int send_idle  = 28;
    int recv_idle  = 52;
    int words_sent = 0;

    waypoint_advance_selector uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic int rand_coord();
        logic [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return int'($signed(v));
    endfunction

    function automatic int offset(logic [COORD_W-1:0] c, int r);
        int base;
        base = $signed(c);
        return base + int'($urandom_range(2 * r)) - r;
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] f, int x, int y, bit last);
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        cx = x[COORD_W-1:0];
        cy = y[COORD_W-1:0];
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {cy, cx};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_word(f, cx, cy, last);
        words_sent++;
    endtask

    // Hold the sender until every queued result has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.expected_targets.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_register(addr, value);
        // read the register back with a fresh setup cycle
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== tracker.register_value(addr))
            tracker.report("register readback", prdata, tracker.register_value(addr));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [RADIUS_W-1:0] reach, logic [RADIUS_W-1:0] skip,
                                 logic [SKIP_W-1:0] bulk, int s_idle, int r_idle);
        drain_results();
        repeat (8) @(posedge clk);
        send_idle = s_idle;
        recv_idle = r_idle;
        reg_write(REG_REACH, PDATA_W'(reach));
        reg_write(REG_SKIP, PDATA_W'(skip));
        reg_write(REG_BULK, PDATA_W'(bulk));
    endtask

    task automatic tick_near();
        int r;
        r = int'(tracker.reach_r);
        r = r + r / 4 + 2;
        if (r > 4000000)
            r = 4000000;
        send_word(FUNC_TICK, offset(tracker.tgt_x, r), offset(tracker.tgt_y, r),
                  1'($urandom_range(1)));
    endtask

    // A path message as a random walk, now and then with a tick or goal inside it
    task automatic send_message();
        int len;
        int x;
        int y;
        bit mark_end;
        len      = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(12, 1);
        mark_end = ($urandom_range(24) != 0);
        if ($urandom_range(4) == 0)
        begin
            x = rand_coord();
            y = rand_coord();
        end
        else
        begin
            x = offset(tracker.tgt_x, 20000);
            y = offset(tracker.tgt_y, 20000);
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                if ($urandom_range(1))
                    tick_near();
                else
                    send_word(FUNC_GOAL, offset(tracker.tgt_x, 3000),
                              offset(tracker.tgt_y, 3000), 1'b0);
            end
            send_word(FUNC_PATH, x, y, mark_end && i == len - 1);
            x = x + int'($urandom_range(12000)) - 6000;
            y = y + int'($urandom_range(12000)) - 6000;
        end
    endtask

    task automatic run_random(int n);
        int stop_at;
        int roll;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                send_message();
            else if (roll < 75)
                repeat ($urandom_range(4, 1)) tick_near();
            else if (roll < 85)
            begin
                if ($urandom_range(1))
                    send_word(FUNC_GOAL, rand_coord(), rand_coord(), 1'($urandom_range(1)));
                else
                    send_word(FUNC_GOAL, offset(tracker.tgt_x, 30000),
                              offset(tracker.tgt_y, 30000), 1'($urandom_range(1)));
            end
            else if (roll < 90)
                send_word(FUNC_SPARE, rand_coord(), rand_coord(), 1'($urandom_range(1)));
            else
                send_word(FUNC_TICK, rand_coord(), rand_coord(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: reach 9175, skip 7864, bulk 7
        send_word(FUNC_GOAL, -8388608, 8388607, 1'b0);
        send_word(FUNC_GOAL, 8388607, -8388608, 1'b1);
        send_word(FUNC_SPARE, rand_coord(), rand_coord(), 1'b1);
        send_word(FUNC_TICK, 0, 0, 1'b0);
        send_word(FUNC_PATH, 1, 1, 1'b0);
        send_word(FUNC_PATH, 2, 2, 1'b1);
        send_word(FUNC_PATH, 77, 77, 1'b0);
        send_word(FUNC_PATH, 1000, 1000, 1'b0);
        send_word(FUNC_PATH, 5000, 1000, 1'b0);
        send_word(FUNC_PATH, 9000, 1000, 1'b0);
        send_word(FUNC_PATH, 13000, 1000, 1'b1);
        send_word(FUNC_TICK, 10174, 1000, 1'b0);    // just inside reach: keep only the last
        send_word(FUNC_TICK, 13000, 1000, 1'b0);    // store now empty
        send_word(FUNC_PATH, 5, 5, 1'b1);
        send_word(FUNC_PATH, 6, 6, 1'b1);           // lone point: store emptied, target held
        send_word(FUNC_PATH, 7, 7, 1'b1);
        send_word(FUNC_PATH, 8, 8, 1'b0);
        send_word(FUNC_PATH, 100, 100, 1'b0);
        send_word(FUNC_GOAL, 0, 0, 1'b0);           // goal and tick inside an open message
        send_word(FUNC_TICK, 0, 0, 1'b0);
        send_word(FUNC_PATH, 200, 200, 1'b1);
        send_word(FUNC_TICK, 9375, 200, 1'b0);      // exactly at reach: no advance
        send_word(FUNC_TICK, 200, 200, 1'b1);

        apply_setting(23'd20000, 23'd15000, 8'd3, 28, 52);
        run_random(95);
        apply_setting(23'h7FFFFF, 23'd0, 8'd0, 28, 52);
        run_random(95);
        apply_setting(23'd0, 23'h7FFFFF, 8'd255, 52, 28);
        run_random(95);
        apply_setting(23'd30000, 23'h7FFFFF, 8'd1, 52, 28);
        run_random(95);
        apply_setting(23'h7FFFFF, 23'h7FFFFF, 8'd255, 0, 0);
        run_random(95);
        apply_setting(23'd12000, 23'd10000, 8'd5, 0, 0);
        run_random(80);

        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_targets.size() == 0)
            $display("[waypoint_advance_selector] OK");
        else
            $display("[waypoint_advance_selector] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[waypoint_advance_selector] ERROR");
        $finish;
    end
endmodule
